>>> src/ctlp_pkg.sv
// Package for the command TLV packet parser.
// Holds the shared constants, the parse phase and status codes, and the event type
// passed from the front end to the back end. It depends on nothing.
package ctlp_pkg;

  localparam int MAX_KEYS     = 16;
  localparam int NUM_COMMANDS = 31;
  localparam int HANDLER_W    = 31;
  localparam int CMD_IDX_W    = $clog2(HANDLER_W);
  localparam int BYTE_W       = 8;
  localparam int LEN_W        = 16;
  localparam int POS_W        = 16;
  localparam int CNT_W        = 5;
  localparam int STATUS_W     = 2;
  localparam int HDR_LEN      = 2;
  localparam int FIFO_DEPTH   = 4;
  localparam int FIFO_AW      = $clog2(FIFO_DEPTH);

  typedef enum logic [2:0] {
    PH_CMD,
    PH_VER,
    PH_KEY,
    PH_LHI,
    PH_LLO,
    PH_VAL,
    PH_SKIP
  } phase_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_DISPATCHED = 2'd0,
    ST_NO_HANDLER = 2'd1,
    ST_TOO_SHORT  = 2'd2
  } status_t;

  localparam logic KIND_RECORD  = 1'b0;
  localparam logic KIND_SUMMARY = 1'b1;

  typedef struct packed {
    logic                has_rec;
    logic                has_sum;
    logic [BYTE_W-1:0]   key;
    logic [LEN_W-1:0]    value_length;
    logic [LEN_W-1:0]    value_offset;
    logic [BYTE_W-1:0]   command_id;
    logic [CNT_W-1:0]    record_count;
    status_t             status;
  } ctlp_event_t;

endpackage

>>> src/command_tlv_packet_parser.sv
// Top level of the command TLV packet parser.
// Joins the byte parser front end, the event queue and the result back end.
// Depends on ctlp_pkg, ctlp_front, ctlp_fifo and ctlp_back.
//
// Packet bytes enter on the input queue port: a transaction takes place when push
// is high and full is low, carrying in_data_byte and in_end_of_packet, which marks
// the final byte of a packet. One byte is taken in every cycle while full is low.
// Results leave on the output queue port: while empty is low the oldest result is
// on the out_ ports, and a transaction takes place when pop is high. A key record
// appears when its value is complete, and a summary with out_last set follows the
// final byte of each packet. A result is registered in the queue before it is
// shown; a byte that yields both a record and a summary gives them on two
// successive pops. The queue between the parser and the result port holds four
// parser events; when the receiver stalls it fills and full rises, and it falls
// again as soon as one event has been drained. The handler mask is written through
// cfg_wr_en and cfg_wr_data and takes effect on the next byte. Reset, synchronous
// and active low on rst_n, clears the mask, empties the queue and puts the parser
// at the command byte of a new packet.
module command_tlv_packet_parser (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             push,
  output logic                             full,
  input  logic [ctlp_pkg::BYTE_W-1:0]      in_data_byte,
  input  logic                             in_end_of_packet,
  output logic                             empty,
  input  logic                             pop,
  output logic                             out_result_kind,
  output logic [ctlp_pkg::BYTE_W-1:0]      out_key,
  output logic [ctlp_pkg::LEN_W-1:0]       out_value_length,
  output logic [ctlp_pkg::LEN_W-1:0]       out_value_offset,
  output logic [ctlp_pkg::BYTE_W-1:0]      out_command_id,
  output logic [ctlp_pkg::CNT_W-1:0]       out_record_count,
  output logic [ctlp_pkg::STATUS_W-1:0]    out_status,
  output logic                             out_last,
  input  logic                             cfg_wr_en,
  input  logic [ctlp_pkg::HANDLER_W-1:0]   cfg_wr_data
);
  import ctlp_pkg::*;

  logic         accept;
  logic         ev_valid;
  ctlp_event_t  ev;
  ctlp_event_t  head;
  logic         head_empty;
  logic         head_rd_en;

  assign accept = push && !full;

  ctlp_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .accept        (accept),
    .data_byte     (in_data_byte),
    .end_of_packet (in_end_of_packet),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data),
    .ev_valid      (ev_valid),
    .ev            (ev)
  );

  ctlp_fifo u_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (ev_valid),
    .wr_data (ev),
    .full    (full),
    .rd_en   (head_rd_en),
    .rd_data (head),
    .empty   (head_empty)
  );

  ctlp_back u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .head         (head),
    .head_empty   (head_empty),
    .head_rd_en   (head_rd_en),
    .empty        (empty),
    .pop          (pop),
    .result_kind  (out_result_kind),
    .key          (out_key),
    .value_length (out_value_length),
    .value_offset (out_value_offset),
    .command_id   (out_command_id),
    .record_count (out_record_count),
    .status       (out_status),
    .last         (out_last)
  );

endmodule

>>> src/ctlp_front.sv
// Front end of the command TLV packet parser: byte parser and handler mask register.
// Classifies each accepted byte and produces one event per byte that completes a
// record or ends a packet. Depends on ctlp_pkg.
module ctlp_front (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                accept,
  input  logic [ctlp_pkg::BYTE_W-1:0]         data_byte,
  input  logic                                end_of_packet,
  input  logic                                cfg_wr_en,
  input  logic [ctlp_pkg::HANDLER_W-1:0]      cfg_wr_data,
  output logic                                ev_valid,
  output ctlp_pkg::ctlp_event_t               ev
);
  import ctlp_pkg::*;

  phase_t                phase_r, phase_nxt;
  logic [POS_W-1:0]      pos_r, pos_nxt;
  logic [BYTE_W-1:0]     cmd_r, cmd_nxt;
  logic [BYTE_W-1:0]     key_r, key_nxt;
  logic [LEN_W-1:0]      len_r, len_nxt;
  logic [LEN_W-1:0]      rem_r, rem_nxt;
  logic [LEN_W-1:0]      vstart_r, vstart_nxt;
  logic [CNT_W-1:0]      cnt_r, cnt_nxt;
  logic [HANDLER_W-1:0]  mask_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_CMD;
      pos_r    <= '0;
      cmd_r    <= '0;
      key_r    <= '0;
      len_r    <= '0;
      rem_r    <= '0;
      vstart_r <= '0;
      cnt_r    <= '0;
      mask_r   <= '0;
    end else begin
      phase_r  <= phase_nxt;
      pos_r    <= pos_nxt;
      cmd_r    <= cmd_nxt;
      key_r    <= key_nxt;
      len_r    <= len_nxt;
      rem_r    <= rem_nxt;
      vstart_r <= vstart_nxt;
      cnt_r    <= cnt_nxt;
      if (cfg_wr_en) begin
        mask_r <= cfg_wr_data;
      end
    end
  end

  always_comb begin
    logic              rec;
    logic [CNT_W-1:0]  cnt_inc;
    logic [LEN_W-1:0]  rec_len;
    logic [LEN_W-1:0]  rec_off;
    status_t           st;

    phase_nxt  = phase_r;
    pos_nxt    = pos_r;
    cmd_nxt    = cmd_r;
    key_nxt    = key_r;
    len_nxt    = len_r;
    rem_nxt    = rem_r;
    vstart_nxt = vstart_r;
    cnt_nxt    = cnt_r;
    rec        = 1'b0;
    cnt_inc    = cnt_r + 1'b1;
    rec_len    = len_r;
    rec_off    = vstart_r;

    case (phase_r)
      PH_CMD: begin
        cmd_nxt   = data_byte;
        phase_nxt = PH_VER;
      end
      PH_VER: begin
        phase_nxt = PH_KEY;
      end
      PH_KEY: begin
        key_nxt   = data_byte;
        phase_nxt = PH_LHI;
      end
      PH_LHI: begin
        len_nxt   = {data_byte, {BYTE_W{1'b0}}};
        phase_nxt = PH_LLO;
      end
      PH_LLO: begin
        len_nxt    = {len_r[LEN_W-1:BYTE_W], data_byte};
        vstart_nxt = pos_r + LEN_W'(1) - LEN_W'(HDR_LEN);
        rec_len    = len_nxt;
        rec_off    = vstart_nxt;
        if (len_nxt == '0) begin
          rec = 1'b1;
        end else begin
          rem_nxt   = len_nxt;
          phase_nxt = PH_VAL;
        end
      end
      PH_VAL: begin
        rem_nxt = rem_r - 1'b1;
        if (rem_nxt == '0) begin
          rec = 1'b1;
        end
      end
      default: begin
      end
    endcase

    if (rec) begin
      cnt_nxt   = cnt_inc;
      phase_nxt = (cnt_inc >= CNT_W'(MAX_KEYS)) ? PH_SKIP : PH_KEY;
    end

    if (pos_r != '1) begin
      pos_nxt = pos_r + 1'b1;
    end

    if (phase_r == PH_CMD) begin
      st = ST_TOO_SHORT;
    end else if ((cmd_r < BYTE_W'(NUM_COMMANDS)) && (cmd_r < BYTE_W'(HANDLER_W)) &&
                 mask_r[cmd_r[CMD_IDX_W-1:0]]) begin
      st = ST_DISPATCHED;
    end else begin
      st = ST_NO_HANDLER;
    end

    ev.has_rec      = rec;
    ev.has_sum      = end_of_packet;
    ev.key          = key_r;
    ev.value_length = rec_len;
    ev.value_offset = rec_off;
    ev.command_id   = (phase_r == PH_CMD) ? data_byte : cmd_r;
    ev.record_count = rec ? cnt_inc : ((phase_r == PH_CMD) ? '0 : cnt_r);
    ev.status       = st;
    ev_valid        = accept && (rec || end_of_packet);

    if (end_of_packet) begin
      phase_nxt  = PH_CMD;
      pos_nxt    = '0;
      cmd_nxt    = '0;
      key_nxt    = '0;
      len_nxt    = '0;
      rem_nxt    = '0;
      vstart_nxt = '0;
      cnt_nxt    = '0;
    end

    if (!accept) begin
      phase_nxt  = phase_r;
      pos_nxt    = pos_r;
      cmd_nxt    = cmd_r;
      key_nxt    = key_r;
      len_nxt    = len_r;
      rem_nxt    = rem_r;
      vstart_nxt = vstart_r;
      cnt_nxt    = cnt_r;
    end
  end

`ifndef SYNTHESIS
  a_eop_restarts: assert property (@(posedge clk) disable iff (!rst_n)
    accept && end_of_packet |=> phase_r == PH_CMD && cnt_r == '0)
    else $error("parser did not return to the command byte after end of packet");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(MAX_KEYS))
    else $error("record count exceeds the record limit");

  a_skip_full: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_SKIP |-> cnt_r == CNT_W'(MAX_KEYS))
    else $error("skipping bytes before the record limit is reached");
`endif

endmodule

>>> src/ctlp_fifo.sv
// Event queue between the front and back ends of the command TLV packet parser.
// A short register queue of parser events with full and empty flags.
// Depends on ctlp_pkg.
module ctlp_fifo (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   wr_en,
  input  ctlp_pkg::ctlp_event_t  wr_data,
  output logic                   full,
  input  logic                   rd_en,
  output ctlp_pkg::ctlp_event_t  rd_data,
  output logic                   empty
);
  import ctlp_pkg::*;

  ctlp_event_t           mem_r [FIFO_DEPTH];
  logic [FIFO_AW-1:0]    wptr_r, wptr_nxt;
  logic [FIFO_AW-1:0]    rptr_r, rptr_nxt;
  logic [FIFO_AW:0]      count_r, count_nxt;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wptr_r] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r  <= '0;
      rptr_r  <= '0;
      count_r <= '0;
    end else begin
      wptr_r  <= wptr_nxt;
      rptr_r  <= rptr_nxt;
      count_r <= count_nxt;
    end
  end

  always_comb begin
    wptr_nxt  = wr_en ? wptr_r + 1'b1 : wptr_r;
    rptr_nxt  = rd_en ? rptr_r + 1'b1 : rptr_r;
    count_nxt = count_r + (FIFO_AW+1)'(wr_en) - (FIFO_AW+1)'(rd_en);
  end

  assign full    = (count_r == (FIFO_AW+1)'(FIFO_DEPTH));
  assign empty   = (count_r == '0);
  assign rd_data = mem_r[rptr_r];

endmodule

>>> src/ctlp_back.sv
// Back end of the command TLV packet parser.
// Expands each queued event into a key record, a packet summary, or both in turn,
// and presents them on the result channel. Depends on ctlp_pkg.
module ctlp_back (
  input  logic                             clk,
  input  logic                             rst_n,
  input  ctlp_pkg::ctlp_event_t            head,
  input  logic                             head_empty,
  output logic                             head_rd_en,
  output logic                             empty,
  input  logic                             pop,
  output logic                             result_kind,
  output logic [ctlp_pkg::BYTE_W-1:0]      key,
  output logic [ctlp_pkg::LEN_W-1:0]       value_length,
  output logic [ctlp_pkg::LEN_W-1:0]       value_offset,
  output logic [ctlp_pkg::BYTE_W-1:0]      command_id,
  output logic [ctlp_pkg::CNT_W-1:0]       record_count,
  output logic [ctlp_pkg::STATUS_W-1:0]    status,
  output logic                             last
);
  import ctlp_pkg::*;

  logic rec_done_r, rec_done_nxt;
  logic show_rec;
  logic take;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rec_done_r <= 1'b0;
    end else begin
      rec_done_r <= rec_done_nxt;
    end
  end

  always_comb begin
    show_rec     = head.has_rec && !rec_done_r;
    take         = pop && !head_empty;
    rec_done_nxt = rec_done_r;
    head_rd_en   = 1'b0;
    if (take) begin
      if (show_rec && head.has_sum) begin
        rec_done_nxt = 1'b1;
      end else begin
        rec_done_nxt = 1'b0;
        head_rd_en   = 1'b1;
      end
    end
  end

  assign empty        = head_empty;
  assign result_kind  = show_rec ? KIND_RECORD : KIND_SUMMARY;
  assign key          = show_rec ? head.key : '0;
  assign value_length = show_rec ? head.value_length : '0;
  assign value_offset = show_rec ? head.value_offset : '0;
  assign command_id   = head.command_id;
  assign record_count = head.record_count;
  assign status       = show_rec ? STATUS_W'(ST_DISPATCHED) : STATUS_W'(head.status);
  assign last         = !show_rec;

`ifndef SYNTHESIS
  a_split_event: assert property (@(posedge clk) disable iff (!rst_n)
    rec_done_r |-> !head_empty && head.has_rec && head.has_sum)
    else $error("record marked delivered without a pending summary at the queue head");
`endif

endmodule
